### sv/cspb_pkg.sv
// ============================================================================
// cspb_pkg: shared types and constants for the clipped sprite blitter
// Holds register indexes, field widths and the job format that the front end
// hands to the back end through the job queue.
// ============================================================================
package cspb_pkg;

    // Default page geometry.
    localparam int unsigned PAGE_WIDTH_DEF  = 320;
    localparam int unsigned PAGE_HEIGHT_DEF = 240;
    localparam int unsigned PAGE_PITCH_DEF  = 160;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ORIGIN_W = 12;
    localparam int unsigned DIM_W    = 10;
    localparam int unsigned PIX_W    = 4;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned COORD_W  = 11;   // page column or row, 0..2047
    localparam int unsigned LANES    = 4;    // pixels per byte at most
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_ART_WIDTH    = 3'd2,
        REG_ART_HEIGHT   = 3'd3,
        REG_TWO_BIT_MODE = 3'd4,
        REG_PALETTE_BASE = 3'd5
    } t_reg_idx;

    // One classified byte: which lanes write, their values and page columns,
    // and the byte address of the start of the page row.
    typedef struct packed {
        logic [LANES-1:0]              mask;
        logic [LANES-1:0][PIX_W-1:0]   val;
        logic [LANES-1:0][COORD_W-1:0] col;
        logic [ADDR_W-1:0]             base;
    } t_job;

endpackage

### sv/cspb_front.sv
// ============================================================================
// cspb_front: configuration registers, art counters and pixel classification
// Unpacks each accepted byte into up to four pixels, drops transparent,
// padding and off-page pixels, and forms one job for the back end.
// ============================================================================
module cspb_front #(
    parameter int unsigned PAGE_WIDTH  = cspb_pkg::PAGE_WIDTH_DEF,
    parameter int unsigned PAGE_HEIGHT = cspb_pkg::PAGE_HEIGHT_DEF,
    parameter int unsigned PAGE_PITCH  = cspb_pkg::PAGE_PITCH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cspb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cspb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_take,
    input  logic [cspb_pkg::BYTE_W-1:0]     i_source_byte,
    output logic                            o_job_valid,
    output cspb_pkg::t_job                  o_job
);
    import cspb_pkg::*;

    localparam int unsigned SC_W   = 14;          // signed page coordinate
    localparam int unsigned PROD_W = 2 * COORD_W;

    logic [ORIGIN_W-1:0] r_origin_x, r_origin_y;
    logic [DIM_W-1:0]    r_art_width, r_art_height;
    logic                r_two_bit;
    logic [PIX_W-1:0]    r_pal_base;
    logic [DIM_W-1:0]    r_col, r_row, n_col, n_row;

    logic signed [SC_W-1:0] page_row;
    logic                   row_ok;
    logic [PROD_W-1:0]      row_prod;
    logic [COORD_W-1:0]     next_col, next_row;
    t_job                   job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_art_width  <= '0;
            r_art_height <= '0;
            r_two_bit    <= 1'b0;
            r_pal_base   <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ORIGIN_X:     r_origin_x   <= i_cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:     r_origin_y   <= i_cfg_data[ORIGIN_W-1:0];
                REG_ART_WIDTH:    r_art_width  <= i_cfg_data[DIM_W-1:0];
                REG_ART_HEIGHT:   r_art_height <= i_cfg_data[DIM_W-1:0];
                REG_TWO_BIT_MODE: r_two_bit    <= i_cfg_data[0];
                REG_PALETTE_BASE: r_pal_base   <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Row classification and the byte address of the page row start.
    always_comb begin
        page_row = SC_W'($signed(r_origin_y)) + $signed({{(SC_W-DIM_W){1'b0}}, r_row});
        row_ok   = (r_row < r_art_height) && (page_row >= 0)
                   && (page_row < $signed(SC_W'(PAGE_HEIGHT)));
        row_prod = {{COORD_W{1'b0}}, page_row[COORD_W-1:0]} * PROD_W'(PAGE_PITCH);
    end

    // Per-lane unpacking and clipping.
    always_comb begin
        logic [COORD_W-1:0]     art_col;
        logic signed [SC_W-1:0] page_col;
        logic [1:0]             two;
        logic [PIX_W-1:0]       v;
        logic                   lane_on;
        job      = '0;
        job.base = row_prod[ADDR_W-1:0];
        for (int k = 0; k < LANES; k++) begin
            art_col  = {1'b0, r_col} + COORD_W'(k);
            page_col = SC_W'($signed(r_origin_x)) + $signed({3'b000, art_col});
            two      = i_source_byte[BYTE_W-2-2*k +: 2];
            if (r_two_bit) begin
                v       = r_pal_base + {2'b00, two} - PIX_W'(1);
                lane_on = (two != 2'b00);
            end else begin
                v       = (k == 0) ? i_source_byte[7:4] : i_source_byte[3:0];
                lane_on = (k < 2) && (v != '0);
            end
            job.val[k]  = v;
            job.col[k]  = page_col[COORD_W-1:0];
            job.mask[k] = lane_on && row_ok && (art_col < {1'b0, r_art_width})
                          && (page_col >= 0)
                          && (page_col < $signed(SC_W'(PAGE_WIDTH)));
        end
    end

    // Art position advance: column by 2 or 4, wrapping the row at the art end.
    always_comb begin
        next_col = {1'b0, r_col} + (r_two_bit ? COORD_W'(4) : COORD_W'(2));
        next_row = {1'b0, r_row} + COORD_W'(1);
        n_col    = next_col[DIM_W-1:0];
        n_row    = r_row;
        if (next_col >= {1'b0, r_art_width}) begin
            n_col = '0;
            n_row = (next_row >= {1'b0, r_art_height}) ? '0 : next_row[DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_job       = job;
    assign o_job_valid = i_take && (job.mask != '0);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_art_width != '0) |-> (r_col < r_art_width || $past(i_cfg_we)
                                 || $past(!i_rst_n) || !$past(i_take)))
        else $error("column counter left the art row");

endmodule

### sv/cspb_queue.sv
// ============================================================================
// cspb_queue: short job queue between front and back end
// Register-based circular buffer with an occupancy count.
// ============================================================================
module cspb_queue #(
    parameter int unsigned DEPTH = cspb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cspb_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output cspb_pkg::t_job o_data
);
    import cspb_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("job queue count overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("job queue count missed a push");

endmodule

### sv/cspb_back.sv
// ============================================================================
// cspb_back: nibble write sequencer
// Walks the write lanes of one job, lowest lane first, and loads one nibble
// write per cycle into the output register while it is empty or popped.
// ============================================================================
module cspb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  cspb_pkg::t_job              i_q_data,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [cspb_pkg::ADDR_W-1:0] o_page_address,
    output logic                        o_high_nibble,
    output logic [cspb_pkg::PIX_W-1:0]  o_pixel_value,
    output logic                        o_last_of_run
);
    import cspb_pkg::*;

    t_job              r_job;
    logic [LANES-1:0]  n_mask;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_addr;
    logic              r_high;
    logic [PIX_W-1:0]  r_val;
    logic              r_last;

    logic [LANES-1:0]   sel, rest;
    logic [PIX_W-1:0]   sel_val;
    logic [COORD_W-1:0] sel_col;
    logic               can_emit, emit, take;

    // Lowest pending lane.
    always_comb begin
        sel     = '0;
        sel_val = '0;
        sel_col = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (r_job.mask[k]) begin
                sel     = LANES'(1) << k;
                sel_val = r_job.val[k];
                sel_col = r_job.col[k];
            end
        end
    end

    always_comb begin
        can_emit = !r_out_valid || i_pop;
        emit     = can_emit && (r_job.mask != '0);
        rest     = r_job.mask & ~sel;
        take     = (r_job.mask == '0) || (emit && rest == '0);
        o_q_pop  = take && !i_q_empty;
        n_mask   = emit ? rest : r_job.mask;
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_addr <= r_job.base + ADDR_W'(sel_col[COORD_W-1:1]);
            r_high <= !sel_col[0];
            r_val  <= sel_val;
            r_last <= (rest == '0);
        end
    end

    // The job register: only its lane mask needs a reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.mask  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_job.mask <= o_q_pop ? i_q_data.mask : n_mask;
            if (o_q_pop) begin
                r_job.val  <= i_q_data.val;
                r_job.col  <= i_q_data.col;
                r_job.base <= i_q_data.base;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_page_address = r_addr;
    assign o_high_nibble  = r_high;
    assign o_pixel_value  = r_val;
    assign o_last_of_run  = r_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (i_q_data.mask != '0))
        else $error("queued job carries no write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !o_q_pop) |=>
            ($countones(r_job.mask) == $countones($past(r_job.mask)) - 1))
        else $error("lane walk did not retire exactly one lane");

endmodule

### sv/clipped_sprite_blit_4bpp_page_top.sv
// ============================================================================
// clipped_sprite_blit_4bpp_page_top: transparent clipped sprite blitter
// Turns packed 4bpp or 2bpp artwork bytes into nibble writes on a 4-bit page.
// ============================================================================
//
//  Channel   Handshake                Payload
//  -------   ----------------------   ---------------------------------------
//  config    i_cfg_we                 i_cfg_index, i_cfg_data
//  source    push / full              i_source_byte
//  writes    pop / empty              o_page_address, o_high_nibble,
//                                     o_pixel_value, o_last_of_run
//
//  The front end takes one byte in every cycle that the job queue has room.
//  The back end issues one nibble write per cycle while the output is popped
//  or empty, one write for each nibble that a byte writes (one to four);
//  bytes with no write never enter the queue and only advance the art counters.
//  The output register is reloaded in the same cycle that its item is
//  popped, so a steady consumer sees one item per cycle while writes are waiting.
//  Reset is synchronous and active low; it clears the config registers and art
//  counters and empties the queue and output; the first byte may follow at once.
//
module clipped_sprite_blit_4bpp_page_top #(
    parameter int unsigned PAGE_WIDTH  = cspb_pkg::PAGE_WIDTH_DEF,
    parameter int unsigned PAGE_HEIGHT = cspb_pkg::PAGE_HEIGHT_DEF,
    parameter int unsigned PAGE_PITCH  = cspb_pkg::PAGE_PITCH_DEF,
    parameter int unsigned QUEUE_DEPTH = cspb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cspb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cspb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [cspb_pkg::BYTE_W-1:0]     i_source_byte,
    input  logic                            pop,
    output logic                            empty,
    output logic [cspb_pkg::ADDR_W-1:0]     o_page_address,
    output logic                            o_high_nibble,
    output logic [cspb_pkg::PIX_W-1:0]      o_pixel_value,
    output logic                            o_last_of_run
);
    import cspb_pkg::*;

    logic take;
    logic job_valid;
    t_job job_in;
    logic q_empty;
    t_job q_data;
    logic q_pop;

    // A byte is taken whenever the queue can hold its job; bytes that write
    // nothing only advance the art counters.
    assign take = push && !full;

    cspb_front #(
        .PAGE_WIDTH  (PAGE_WIDTH),
        .PAGE_HEIGHT (PAGE_HEIGHT),
        .PAGE_PITCH  (PAGE_PITCH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_take        (take),
        .i_source_byte (i_source_byte),
        .o_job_valid   (job_valid),
        .o_job         (job_in)
    );

    cspb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    cspb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_data),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_page_address (o_page_address),
        .o_high_nibble  (o_high_nibble),
        .o_pixel_value  (o_pixel_value),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

### test/clipped_sprite_blit_4bpp_page_top_test.sv
// ============================================================================
// clipped_sprite_blit_4bpp_page_top_test: self-checking bench for the blitter
// Streams packed 4bpp and 2bpp artwork bytes through the source queue under
// many register settings, predicts every nibble write from its own copy of
// the registers and art counters, and checks each write that is popped.
// ============================================================================
`timescale 1ns / 1ps

module clipped_sprite_blit_4bpp_page_top_test;

    import cspb_pkg::*;

    // Page geometry of the default build.
    localparam int PAGE_W     = PAGE_WIDTH_DEF;
    localparam int PAGE_H     = PAGE_HEIGHT_DEF;
    localparam int PAGE_PITCH = PAGE_PITCH_DEF;

    // Bench sizing. The stuck limit is far above the longest quiet stretch of
    // a correct run: a receiver stall behind a 4-write byte plus the pause at
    // a phase boundary.
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BYTES   = 28;
    localparam int SETTLE_CYCLES = 8;
    localparam int STUCK_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    // One nibble write as it leaves the block.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              hi_nib;
        logic [PIX_W-1:0]  pix;
        logic              last_mark;
    } t_nibble_write;

    // Clock, reset and every block input start at a known value.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  push          = 1'b0;
    logic [BYTE_W-1:0]     i_source_byte = '0;
    logic                  pop           = 1'b0;
    logic                  full;
    logic                  empty;
    logic [ADDR_W-1:0]     o_page_address;
    logic                  o_high_nibble;
    logic [PIX_W-1:0]      o_pixel_value;
    logic                  o_last_of_run;

    // Shadow copy of the registers and of the art position counters.
    logic signed [ORIGIN_W-1:0] cfg_origin_x = '0;
    logic signed [ORIGIN_W-1:0] cfg_origin_y = '0;
    logic [DIM_W-1:0]           cfg_art_width  = '0;
    logic [DIM_W-1:0]           cfg_art_height = '0;
    logic                       cfg_two_bit    = 1'b0;
    logic [PIX_W-1:0]           cfg_palette    = '0;
    logic [DIM_W-1:0]           col_pos = '0;
    logic [DIM_W-1:0]           row_pos = '0;

    // Artwork bytes waiting for the driver, and the writes they should cause.
    logic [BYTE_W-1:0] pending_bytes[$];
    t_nibble_write     expected_writes[$];
    int                bytes_left  = 0;
    int                error_count = 0;
    int                stuck_cycles = 0;
    int                send_gap = 0;
    int                recv_gap = 0;
    logic              idle_bursts = 1'b1;

    always #6 i_clk = ~i_clk;

    clipped_sprite_blit_4bpp_page_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_source_byte  (i_source_byte),
        .pop            (pop),
        .empty          (empty),
        .o_page_address (o_page_address),
        .o_high_nibble  (o_high_nibble),
        .o_pixel_value  (o_pixel_value),
        .o_last_of_run  (o_last_of_run)
    );

    // Works out the nibble writes of one accepted artwork byte and advances
    // the art counters. Pixel k of the byte sits at artwork column col_pos+k.
    task automatic blit_byte(input logic [BYTE_W-1:0] src);
        int            lanes;
        int            page_row;
        int            page_col;
        int            col;
        logic [1:0]    pair;
        logic [3:0]    pix;
        logic          row_on_page;
        t_nibble_write batch[$];
        t_nibble_write w;
        lanes = cfg_two_bit ? 4 : 2;
        page_row = int'(cfg_origin_y) + int'(row_pos);
        // A row beyond the art height (left over after a register change)
        // writes nothing, and neither does a row above or below the page.
        row_on_page = (row_pos < cfg_art_height) && page_row >= 0 && page_row < PAGE_H;
        for (int k = 0; k < lanes; k++) begin
            col = int'(col_pos) + k;
            // Pixels at or past the art width are row padding.
            if (!row_on_page || col >= int'(cfg_art_width))
                continue;
            if (cfg_two_bit) begin
                pair = src[7 - 2 * k -: 2];
                if (pair == 2'd0)
                    continue;
                // Value v maps to palette_base + v - 1, wrapping at 16.
                pix = cfg_palette + 4'(pair) - 4'd1;
            end else begin
                pix = (k == 0) ? src[7:4] : src[3:0];
                if (pix == 4'd0)
                    continue;
            end
            page_col = int'(cfg_origin_x) + col;
            if (page_col < 0 || page_col >= PAGE_W)
                continue;
            w.addr      = 16'(page_row * PAGE_PITCH + page_col / 2);
            w.hi_nib    = (page_col % 2 == 0);
            w.pix       = pix;
            w.last_mark = 1'b0;
            batch.push_back(w);
        end
        // The final write of the byte carries the last mark.
        if (batch.size() != 0)
            batch[batch.size() - 1].last_mark = 1'b1;
        foreach (batch[i])
            expected_writes.push_back(batch[i]);
        // A row ends once the column reaches the art width; the art ends once
        // the row reaches the art height. A zero width ends a row at every byte.
        if (int'(col_pos) + lanes >= int'(cfg_art_width)) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= int'(cfg_art_height))
                row_pos = '0;
            else
                row_pos = row_pos + 10'd1;
        end else begin
            col_pos = 10'(int'(col_pos) + lanes);
        end
    endtask

    task automatic flag_write(input string why, input t_nibble_write want,
                              input t_nibble_write got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s: expected addr %0d hi %0b pix %0d last %0b, %s %0d hi %0b pix %0d last %0b",
                     why, want.addr, want.hi_nib, want.pix, want.last_mark,
                     "got addr", got.addr, got.hi_nib, got.pix, got.last_mark);
    endtask

    // Source driver. The prediction is made at the edge that accepts a byte,
    // so it always sees the registers that the block used for that byte.
    // A byte that is offered stays offered until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap = 0;
        end else begin
            if (push && !full) begin
                blit_byte(i_source_byte);
                bytes_left--;
            end
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (idle_bursts && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(1, 8) - 1;
                    push <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    push <= 1'b1;
                    i_source_byte <= pending_bytes.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Write monitor. Each popped write is matched against the oldest
    // prediction; pop is stalled in random bursts while idling is enabled.
    always @(posedge i_clk) begin
        t_nibble_write got;
        t_nibble_write want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            recv_gap = 0;
        end else begin
            if (pop && !empty) begin
                got = {o_page_address, o_high_nibble, o_pixel_value, o_last_of_run};
                if (expected_writes.size() == 0) begin
                    flag_write("unexpected nibble write", '0, got);
                end else begin
                    want = expected_writes.pop_front();
                    if (got.addr !== want.addr || got.hi_nib !== want.hi_nib ||
                        got.pix !== want.pix || got.last_mark !== want.last_mark)
                        flag_write("nibble write mismatch", want, got);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else if (idle_bursts && $urandom_range(0, 4) == 0) begin
                recv_gap = $urandom_range(1, 8) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Register write; the shadow copy follows once the block has taken it.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X:     cfg_origin_x   = data;
            REG_ORIGIN_Y:     cfg_origin_y   = data;
            REG_ART_WIDTH:    cfg_art_width  = data[DIM_W-1:0];
            REG_ART_HEIGHT:   cfg_art_height = data[DIM_W-1:0];
            REG_TWO_BIT_MODE: cfg_two_bit    = data[0];
            REG_PALETTE_BASE: cfg_palette    = data[PIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int ox, input int oy, input int wid, input int hgt,
                             input int mode, input int pal);
        write_reg(REG_ORIGIN_X, 12'(ox));
        write_reg(REG_ORIGIN_Y, 12'(oy));
        write_reg(REG_ART_WIDTH, 12'(wid));
        write_reg(REG_ART_HEIGHT, 12'(hgt));
        write_reg(REG_TWO_BIT_MODE, 12'(mode));
        write_reg(REG_PALETTE_BASE, 12'(pal));
    endtask

    task automatic send(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_left++;
    endtask

    // Holds until every byte is taken and every write has come out. Bytes
    // without writes never reach the output, so a short settle follows.
    task automatic wait_idle();
        while (bytes_left != 0 || expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random artwork byte; each 2-bit pair is often cleared so that
    // transparent pixels are common in both modes.
    function automatic logic [BYTE_W-1:0] art_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < 4; i++)
                if ($urandom_range(0, 3) == 0)
                    b[2 * i +: 2] = 2'b00;
        end
        return b;
    endfunction

    // Origins mostly keep the art near the page, sometimes at the extremes.
    function automatic int pick_origin(input int span);
        int o;
        case ($urandom_range(0, 9))
            0:       o = -2048;
            1:       o = 2047;
            default: o = int'($urandom_range(0, span + 40)) - 20;
        endcase
        return o;
    endfunction

    function automatic int pick_size(input int typical);
        int s;
        case ($urandom_range(0, 9))
            0:       s = 0;
            1:       s = 1023;
            default: s = $urandom_range(1, typical);
        endcase
        return s;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset: zero width and height, so every byte ends a
        // row and nothing is written.
        send(8'hFF); send(8'hA5);
        wait_idle();

        // 4bpp, width 5: the last byte of each row has a padding pixel, zero
        // nibbles are transparent, and the second row wraps the art.
        configure(0, 0, 5, 2, 0, 0);
        send(8'hFF); send(8'h0F); send(8'hF1);
        send(8'h00); send(8'h9A); send(8'h7B);
        wait_idle();

        // 2bpp at the bottom right corner: columns past the page edge and the
        // row below the page are clipped; palette base 15 wraps the values.
        configure(318, 239, 8, 2, 1, 15);
        send(8'hFF); send(8'hE4); send(8'h1B); send(8'h55);
        wait_idle();

        // Negative origin: the top row and the left columns fall off the page.
        // Two rows are sent, leaving the counters on row 2.
        configure(-3, -1, 7, 3, 1, 0);
        send(8'hC6); send(8'h39); send(8'hFF); send(8'h1E);
        wait_idle();

        // Height drops to 1 under the counters: row 2 is stale and writes
        // nothing until the art wraps; the mode also changes mid-art.
        configure(-3, 5, 7, 1, 0, 0);
        send(8'h88); send(8'h77); send(8'h66);
        send(8'h55); send(8'h4F); send(8'hF4);
        wait_idle();

        // Random phases; the counters carry over each register change. Two
        // phases run with no idling at all, the last one among them.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_bursts = !(p == 5 || p == RANDOM_PHASES - 1);
            if (p == 0)
                configure(2047, -2048, 1023, 1023, 1, 15);
            else if (p == 1)
                configure(-2048, 2047, 1023, 0, 0, 0);
            else
                configure(pick_origin(PAGE_W), pick_origin(PAGE_H), pick_size(24),
                          pick_size(8), $urandom_range(0, 1), $urandom_range(0, 15));
            repeat (PHASE_BYTES) send(art_byte());
            wait_idle();
        end

        if (error_count == 0 && expected_writes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
